@@ sv/dag_task_list_scheduler_unit_defines.svh @@
// assertion macros for the list scheduler
`ifndef DAG_TASK_LIST_SCHEDULER_UNIT_DEFINES_SVH
`define DAG_TASK_LIST_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication on i_clk, off while i_rst_n is low
`define DTLS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on i_clk, off while i_rst_n is low
`define DTLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/dtls_pkg.sv @@
`default_nettype none

package dtls_pkg;

    typedef enum logic [1:0] {
        REQ_SET_DUR  = 2'd0,
        REQ_ADD_EDGE = 2'd1,
        REQ_TICK     = 2'd2
    } t_req;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] task_id;
        logic [5:0] pred_task;
        logic [7:0] duration;
    } t_in;

    typedef struct packed {
        logic        assign_valid;
        logic [3:0]  proc_id;
        logic [5:0]  started_task;
        logic [12:0] tick_time;
        logic        all_started;
        logic        last;
    } t_out;

endpackage

`default_nettype wire

@@ sv/dag_task_list_scheduler_unit.sv @@
// Precedence-graph list scheduler. Duration and edge requests are applied in the idle state. A tick
// request first ORs the dependency rows of the tasks in use into a pending mask, one row per
// cycle, then walks tasks and processors with one shared compare step per cycle, then sends
// one result per pairing or one empty result, one per cycle while the output is free, and
// finally steps through all MAX_PROCS processors with a single shared decrementer, counting
// down the busy ones. A tick once all tasks have started sends only the empty result and
// skips the countdown. The block stalls its input for the whole of a tick.
`default_nettype none

`include "dag_task_list_scheduler_unit_defines.svh"

module dag_task_list_scheduler_unit #(
    parameter int MAX_TASKS = 32,
    parameter int MAX_PROCS = 8
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [dtls_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [dtls_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire  dtls_pkg::t_in                  i_in,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output dtls_pkg::t_out                       o_out
);

    import dtls_pkg::*;

    localparam int TW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TCW = $clog2(MAX_TASKS + 1);
    localparam int PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int PCW = $clog2(MAX_PROCS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PEND,
        S_SCAN,
        S_EMIT,
        S_COUNT
    } t_state;

    t_state               r_state;
    logic [MAX_TASKS-1:0] r_rows [MAX_TASKS];
    logic [7:0]           r_dur [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_started;
    logic [MAX_TASKS-1:0] r_pending;
    logic [MAX_PROCS-1:0] r_busy;
    logic [7:0]           r_rem [MAX_PROCS];
    logic [TW-1:0]        r_cur [MAX_PROCS];
    logic [3:0]           r_pair_proc [MAX_PROCS];
    logic [5:0]           r_pair_task [MAX_PROCS];
    logic [12:0]          r_time;
    logic [5:0]           r_task_count;
    logic [3:0]           r_proc_count;
    logic [TCW-1:0]       r_t;
    logic [PCW-1:0]       r_p;
    logic [PCW-1:0]       r_npairs;
    logic [PCW-1:0]       r_e;
    logic                 r_skip;
    logic                 r_out_valid;
    t_out                 r_out;

    logic [TCW-1:0]       w_nt;
    logic [PCW-1:0]       w_np;
    logic [MAX_TASKS-1:0] w_use_mask;
    logic                 w_all;
    logic                 w_tid_ok;
    logic                 w_pid_ok;
    logic [TW-1:0]        w_tid_idx;
    logic [TW-1:0]        w_pid_idx;
    logic [TW-1:0]        w_t_idx;
    logic [PW-1:0]        w_p_idx;
    logic                 w_ready;
    logic                 w_scan_end;
    logic [7:0]           w_rem;
    logic [7:0]           w_rem_dec;
    logic                 w_cnt_last;
    logic                 w_tick_end;
    logic                 w_out_free;
    logic                 w_emit_last;
    t_out                 w_emit;
    logic [MAX_PROCS-1:0] w_rem_zero;
    logic                 w_busy_zero;

    // saturated counts in use
    always_comb begin
        if (r_task_count == 6'd0) begin
            w_nt = TCW'(1);
        end else if (7'(r_task_count) > 7'(MAX_TASKS)) begin
            w_nt = TCW'(MAX_TASKS);
        end else begin
            w_nt = TCW'(r_task_count);
        end
        if (r_proc_count == 4'd0) begin
            w_np = PCW'(1);
        end else if (5'(r_proc_count) > 5'(MAX_PROCS)) begin
            w_np = PCW'(MAX_PROCS);
        end else begin
            w_np = PCW'(r_proc_count);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_TASKS; i++) begin
            w_use_mask[i] = (TCW'(i) < w_nt);
        end
        for (int j = 0; j < MAX_PROCS; j++) begin
            w_rem_zero[j] = (r_rem[j] == 8'd0);
        end
    end

    assign w_all       = &(r_started | ~w_use_mask);
    assign w_busy_zero = |(r_busy & w_rem_zero);

    assign w_tid_ok  = (i_in.task_id != 6'd0) && (7'(i_in.task_id) <= 7'(MAX_TASKS));
    assign w_pid_ok  = (i_in.pred_task != 6'd0) && (7'(i_in.pred_task) <= 7'(MAX_TASKS));
    assign w_tid_idx = TW'(i_in.task_id - 6'd1);
    assign w_pid_idx = TW'(i_in.pred_task - 6'd1);

    assign w_t_idx    = r_t[TW-1:0];
    assign w_p_idx    = r_p[PW-1:0];
    assign w_scan_end = (r_t >= w_nt) || (r_p >= w_np);
    assign w_ready    = !r_started[w_t_idx] && !r_pending[w_t_idx];

    // shared countdown unit
    assign w_rem      = r_rem[w_p_idx];
    assign w_rem_dec  = (w_rem != 8'd0) ? (w_rem - 8'd1) : 8'd0;
    assign w_cnt_last = (r_p == PCW'(MAX_PROCS - 1));
    assign w_tick_end = (r_state == S_COUNT) && w_cnt_last;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_emit_last = (r_npairs == PCW'(0)) || (r_e == (r_npairs - PCW'(1)));

    always_comb begin
        w_emit.tick_time   = r_time;
        w_emit.all_started = w_all;
        w_emit.last        = w_emit_last;
        if (r_npairs == PCW'(0)) begin
            w_emit.assign_valid = 1'b0;
            w_emit.proc_id      = 4'd0;
            w_emit.started_task = 6'd0;
        end else begin
            w_emit.assign_valid = 1'b1;
            w_emit.proc_id      = r_pair_proc[r_e[PW-1:0]];
            w_emit.started_task = r_pair_task[r_e[PW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_rows[i] <= '0;
                r_dur[i]  <= 8'd1;
            end
            for (int j = 0; j < MAX_PROCS; j++) begin
                r_rem[j] <= 8'd0;
                r_cur[j] <= '0;
            end
            r_started    <= '0;
            r_pending    <= '0;
            r_busy       <= '0;
            r_time       <= 13'd0;
            r_task_count <= 6'd1;
            r_proc_count <= 4'd1;
            r_t          <= '0;
            r_p          <= '0;
            r_npairs     <= '0;
            r_e          <= '0;
            r_skip       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TASK_COUNT: r_task_count <= i_cfg_data;
                    CFG_PROC_COUNT: r_proc_count <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        case (i_in.req_type)
                            REQ_SET_DUR: begin
                                if (w_tid_ok) begin
                                    r_dur[w_tid_idx] <= (i_in.duration == 8'd0) ?
                                                        8'd1 : i_in.duration;
                                end
                            end
                            REQ_ADD_EDGE: begin
                                if (w_tid_ok && w_pid_ok) begin
                                    r_rows[w_pid_idx][w_tid_idx] <= 1'b1;
                                end
                            end
                            REQ_TICK: begin
                                r_npairs <= '0;
                                r_e      <= '0;
                                if (w_all) begin
                                    r_skip  <= 1'b1;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_skip    <= 1'b0;
                                    r_pending <= '0;
                                    r_t       <= '0;
                                    r_state   <= S_PEND;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                // gather pending successors, one row a cycle
                S_PEND: begin
                    r_pending <= r_pending | r_rows[w_t_idx];
                    if (r_t == (w_nt - TCW'(1))) begin
                        r_t     <= '0;
                        r_p     <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_t <= r_t + TCW'(1);
                    end
                end

                // pair ready tasks with idle processors
                S_SCAN: begin
                    if (w_scan_end) begin
                        r_state <= S_EMIT;
                    end else if (!w_ready) begin
                        r_t <= r_t + TCW'(1);
                    end else if (r_busy[w_p_idx]) begin
                        r_p <= r_p + PCW'(1);
                    end else begin
                        r_busy[w_p_idx]                 <= 1'b1;
                        r_rem[w_p_idx]                  <= r_dur[w_t_idx];
                        r_cur[w_p_idx]                  <= w_t_idx;
                        r_started[w_t_idx]              <= 1'b1;
                        r_pair_proc[r_npairs[PW-1:0]]   <= 4'(r_p) + 4'd1;
                        r_pair_task[r_npairs[PW-1:0]]   <= 6'(r_t) + 6'd1;
                        r_npairs                        <= r_npairs + PCW'(1);
                        r_t                             <= r_t + TCW'(1);
                        r_p                             <= r_p + PCW'(1);
                    end
                end

                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= w_emit;
                        if (w_emit_last) begin
                            if (r_skip) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_p     <= '0;
                                r_state <= S_COUNT;
                            end
                        end else begin
                            r_e <= r_e + PCW'(1);
                        end
                    end
                end

                // one processor a cycle through the shared decrementer
                S_COUNT: begin
                    if (r_busy[w_p_idx]) begin
                        r_rem[w_p_idx] <= w_rem_dec;
                        if (w_rem_dec == 8'd0) begin
                            r_rows[r_cur[w_p_idx]] <= '0;
                            r_cur[w_p_idx]         <= '0;
                            r_busy[w_p_idx]        <= 1'b0;
                        end
                    end
                    if (w_cnt_last) begin
                        r_time  <= r_time + 13'd1;
                        r_state <= S_IDLE;
                    end else begin
                        r_p <= r_p + PCW'(1);
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `DTLS_ASSERT_IMP(a_idle_busy, r_state == S_IDLE, !w_busy_zero, "busy processor at zero")
    `DTLS_ASSERT_IMP(a_scan_bound, r_state == S_SCAN, r_npairs <= r_p, "pairing overrun")
    `DTLS_ASSERT_NEXT(a_time, w_tick_end, r_time == 13'($past(r_time) + 13'd1), "time stuck")

endmodule

`default_nettype wire
